// ===== rtl/nrl_pkg.sv =====
package nrl_pkg;

    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int RSSI_W      = 9;
    localparam int SNR_W       = 8;
    localparam int HOP_W       = 3;
    localparam int LAT_W       = 31;
    localparam int LON_W       = 32;
    localparam int ALT_W       = 32;
    localparam int SLOT_OUT_W  = 5;
    localparam int COUNT_OUT_W = 6;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] seen;
    } key_rec_t;

    typedef struct packed {
        logic                    flag;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic signed [ALT_W-1:0] alt;
    } pos_rec_t;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi;
        logic signed [SNR_W-1:0]  snr;
        logic [HOP_W-1:0]         hop;
        pos_rec_t                 pos;
    } info_rec_t;

    typedef struct packed {
        logic start;
        logic check;
    } scan_ctl_t;

endpackage

// ===== rtl/neighbor_roster_lru_table_core.sv =====
// One transaction at a time: s_ready is high only in idle; the entries held are then
// scanned with one key memory read per cycle, and the result is decided and written.
// The write state also waits while the previous result still waits in the output
// register.
// Reset (aresetn, synchronous) empties the roster and clears control; memories are
// not cleared, only entries below the entry count are read.
module neighbor_roster_lru_table_core
    import nrl_pkg::*;
#(
    parameter int ROSTER_DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ID_W-1:0]          s_sender_id,
    input  logic signed [RSSI_W-1:0] s_signal_rssi,
    input  logic signed [SNR_W-1:0]  s_signal_snr,
    input  logic [HOP_W-1:0]         s_hop_count,
    input  logic [TIME_W-1:0]        s_now_ms,
    input  logic                     s_position_present,
    input  logic signed [LAT_W-1:0]  s_latitude,
    input  logic signed [LON_W-1:0]  s_longitude,
    input  logic signed [ALT_W-1:0]  s_altitude,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SLOT_OUT_W-1:0]    m_slot_index,
    output logic                     m_was_new,
    output logic                     m_did_evict,
    output logic [ID_W-1:0]          m_evicted_id,
    output logic [COUNT_OUT_W-1:0]   m_entry_count
);

    localparam int AW = (ROSTER_DEPTH > 1) ? $clog2(ROSTER_DEPTH) : 1;
    localparam int CW = $clog2(ROSTER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ROSTER_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic          chk_valid_reg;
    logic [AW-1:0] chk_idx_reg;
    logic          issue;
    logic          s_accept;
    logic          out_free;

    logic [ID_W-1:0]          in_id_reg;
    logic signed [RSSI_W-1:0] in_rssi_reg;
    logic signed [SNR_W-1:0]  in_snr_reg;
    logic [HOP_W-1:0]         in_hop_reg;
    logic [TIME_W-1:0]        in_now_reg;
    logic                     in_pos_reg;
    logic signed [LAT_W-1:0]  in_lat_reg;
    logic signed [LON_W-1:0]  in_lon_reg;
    logic signed [ALT_W-1:0]  in_alt_reg;

    logic [AW-1:0]   slot_reg, slot_next;
    logic            new_reg, new_next;
    logic            evict_reg, evict_next;
    logic [ID_W-1:0] old_id_reg, old_id_next;

    logic                   m_valid_reg;
    logic [SLOT_OUT_W-1:0]  m_slot_reg;
    logic                   m_new_reg;
    logic                   m_evict_reg;
    logic [ID_W-1:0]        m_old_id_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    scan_ctl_t       scan_ctl;
    logic            found;
    logic [AW-1:0]   match_slot;
    logic [AW-1:0]   min_slot;
    logic [ID_W-1:0] min_id;

    key_rec_t  key_rd_data, key_wr_data;
    info_rec_t info_rd_data, info_wr_data;
    logic      mem_we;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = (state_reg == ST_SCAN) && (issue_cnt_reg < count_reg);
    assign mem_we   = (state_reg == ST_WRITE) && out_free;

    assign scan_ctl.start = s_accept;
    assign scan_ctl.check = chk_valid_reg;

    nrl_scan #(
        .AW(AW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .chk_idx    (chk_idx_reg),
        .rec        (key_rd_data),
        .search_id  (in_id_reg),
        .found      (found),
        .match_slot (match_slot),
        .min_slot   (min_slot),
        .min_id     (min_id)
    );

    always_comb begin
        key_wr_data.id   = in_id_reg;
        key_wr_data.seen = in_now_reg;
        info_wr_data.rssi = in_rssi_reg;
        info_wr_data.snr  = in_snr_reg;
        info_wr_data.hop  = in_hop_reg;
        if (in_pos_reg) begin
            info_wr_data.pos.flag = 1'b1;
            info_wr_data.pos.lat  = in_lat_reg;
            info_wr_data.pos.lon  = in_lon_reg;
            info_wr_data.pos.alt  = in_alt_reg;
        end else if (new_reg) begin
            info_wr_data.pos = '0;
        end else begin
            info_wr_data.pos = info_rd_data.pos;
        end
    end

    nrl_mem #(
        .DEPTH(ROSTER_DEPTH),
        .AW   (AW)
    ) u_mem (
        .aclk         (aclk),
        .key_rd_addr  (issue_cnt_reg[AW-1:0]),
        .key_rd_data  (key_rd_data),
        .key_we       (mem_we),
        .key_wr_addr  (slot_reg),
        .key_wr_data  (key_wr_data),
        .info_rd_addr (slot_next),
        .info_rd_data (info_rd_data),
        .info_we      (mem_we),
        .info_wr_addr (slot_reg),
        .info_wr_data (info_wr_data)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_cnt_next = issue_cnt_reg;
        slot_next      = slot_reg;
        new_next       = new_reg;
        evict_next     = evict_reg;
        old_id_next    = old_id_reg;
        case (state_reg)
            ST_IDLE: begin
                issue_cnt_next = '0;
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end else if (!chk_valid_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (found) begin
                    slot_next   = match_slot;
                    new_next    = 1'b0;
                    evict_next  = 1'b0;
                    old_id_next = '0;
                end else if (count_reg < DEPTH_C) begin
                    slot_next   = count_reg[AW-1:0];
                    new_next    = 1'b1;
                    evict_next  = 1'b0;
                    old_id_next = '0;
                    count_next  = count_reg + 1'b1;
                end else begin
                    slot_next   = min_slot;
                    new_next    = 1'b1;
                    evict_next  = 1'b1;
                    old_id_next = min_id;
                end
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_valid_reg <= issue;
            if (mem_we) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= issue_cnt_reg[AW-1:0];
        slot_reg    <= slot_next;
        new_reg     <= new_next;
        evict_reg   <= evict_next;
        old_id_reg  <= old_id_next;
        if (s_accept) begin
            in_id_reg   <= s_sender_id;
            in_rssi_reg <= s_signal_rssi;
            in_snr_reg  <= s_signal_snr;
            in_hop_reg  <= s_hop_count;
            in_now_reg  <= s_now_ms;
            in_pos_reg  <= s_position_present;
            in_lat_reg  <= s_latitude;
            in_lon_reg  <= s_longitude;
            in_alt_reg  <= s_altitude;
        end
        if (mem_we) begin
            m_slot_reg   <= SLOT_OUT_W'(slot_reg);
            m_new_reg    <= new_reg;
            m_evict_reg  <= evict_reg;
            m_old_id_reg <= old_id_reg;
            m_count_reg  <= COUNT_OUT_W'(count_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot_index  = m_slot_reg;
    assign m_was_new     = m_new_reg;
    assign m_did_evict   = m_evict_reg;
    assign m_evicted_id  = m_old_id_reg;
    assign m_entry_count = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond roster depth");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) && evict_reg |-> (count_reg == DEPTH_C) && new_reg)
        else $error("eviction while roster not full");

    a_match_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) && found |-> (CW'(match_slot) < count_reg))
        else $error("matched slot beyond entry count");

    a_no_evict_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_evict_reg |-> (m_old_id_reg == '0))
        else $error("evicted id set without eviction");

endmodule

// ===== rtl/nrl_mem.sv =====
module nrl_mem
    import nrl_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic [AW-1:0] key_rd_addr,
    output key_rec_t      key_rd_data,
    input  logic          key_we,
    input  logic [AW-1:0] key_wr_addr,
    input  key_rec_t      key_wr_data,
    input  logic [AW-1:0] info_rd_addr,
    output info_rec_t     info_rd_data,
    input  logic          info_we,
    input  logic [AW-1:0] info_wr_addr,
    input  info_rec_t     info_wr_data
);

    key_rec_t  key_mem  [DEPTH];
    info_rec_t info_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
        key_rd_data <= key_mem[key_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[info_wr_addr] <= info_wr_data;
        end
        info_rd_data <= info_mem[info_rd_addr];
    end

endmodule

// ===== rtl/nrl_scan.sv =====
module nrl_scan
    import nrl_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  scan_ctl_t       ctl,
    input  logic [AW-1:0]   chk_idx,
    input  key_rec_t        rec,
    input  logic [ID_W-1:0] search_id,
    output logic            found,
    output logic [AW-1:0]   match_slot,
    output logic [AW-1:0]   min_slot,
    output logic [ID_W-1:0] min_id
);

    logic              found_reg;
    logic [AW-1:0]     match_slot_reg;
    logic [AW-1:0]     min_slot_reg;
    logic [ID_W-1:0]   min_id_reg;
    logic [TIME_W-1:0] min_seen_reg;
    logic              is_match;
    logic              is_older;

    assign is_match = (rec.id == search_id);
    assign is_older = (chk_idx == '0) || (rec.seen < min_seen_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (ctl.check && is_match) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.check) begin
            if (is_match && !found_reg) begin
                match_slot_reg <= chk_idx;
            end
            if (is_older) begin
                min_seen_reg <= rec.seen;
                min_slot_reg <= chk_idx;
                min_id_reg   <= rec.id;
            end
        end
    end

    assign found      = found_reg;
    assign match_slot = match_slot_reg;
    assign min_slot   = min_slot_reg;
    assign min_id     = min_id_reg;

endmodule

// ===== dv/tb_neighbor_roster_lru_table_core.sv =====
`timescale 1ns / 1ps

module tb_neighbor_roster_lru_table_core
    import nrl_pkg::*;
();

    localparam int ROSTER_DEPTH = 32;
    localparam int DIRECTED_IDS = 15;
    localparam int RANDOM_ITEMS = 930;
    localparam int POOL_SIZE    = 48;
    localparam int DRAIN_CYCLES = ROSTER_DEPTH + 8;
    localparam int IDLE_LIMIT   = 2000;

    typedef enum int {PH_CHURN, PH_TIED, PH_NOISE} phase_kind_t;

    typedef struct {
        logic [ID_W-1:0]          sender_id;
        logic signed [RSSI_W-1:0] rssi;
        logic signed [SNR_W-1:0]  snr;
        logic [HOP_W-1:0]         hops;
        logic [TIME_W-1:0]        now_ms;
        logic                     has_pos;
        logic signed [LAT_W-1:0]  lat;
        logic signed [LON_W-1:0]  lon;
        logic signed [ALT_W-1:0]  alt;
    } packet_t;

    typedef struct {
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   was_new;
        logic                   did_evict;
        logic [ID_W-1:0]        evicted_id;
        logic [COUNT_OUT_W-1:0] count;
    } roster_update_t;

    class roster_scoreboard;
        logic [ID_W-1:0]   ids  [ROSTER_DEPTH];
        logic [TIME_W-1:0] seen [ROSTER_DEPTH];
        int held;
        roster_update_t awaited[$];
        int errors, checked, refreshes, appends, evictions, tied;

        function new();
            held = 0;
            errors = 0;
            checked = 0;
            refreshes = 0;
            appends = 0;
            evictions = 0;
            tied = 0;
        endfunction

        // roster lookup, append or oldest-entry replacement for one packet
        function void note_packet(packet_t p);
            roster_update_t u;
            int slot, ties;
            bit hit;
            hit = 1'b0;
            slot = 0;
            for (int s = 0; s < held; s++) begin
                if (!hit && ids[s] == p.sender_id) begin
                    hit = 1'b1;
                    slot = s;
                end
            end
            u.was_new = !hit;
            u.did_evict = 1'b0;
            u.evicted_id = '0;
            if (hit) begin
                refreshes++;
            end else if (held < ROSTER_DEPTH) begin
                slot = held;
                held++;
                appends++;
            end else begin
                // plain unsigned compare, lowest slot wins a tie
                ties = 1;
                for (int s = 1; s < ROSTER_DEPTH; s++) begin
                    if (seen[s] < seen[slot]) begin
                        slot = s;
                        ties = 1;
                    end else if (seen[s] == seen[slot]) begin
                        ties++;
                    end
                end
                u.did_evict = 1'b1;
                u.evicted_id = ids[slot];
                evictions++;
                if (ties > 1) tied++;
            end
            ids[slot] = p.sender_id;
            seen[slot] = p.now_ms;
            u.slot = SLOT_OUT_W'(slot);
            u.count = COUNT_OUT_W'(held);
            awaited.push_back(u);
        endfunction

        function void check_result(roster_update_t got);
            roster_update_t exp;
            if (awaited.size() == 0) begin
                $error("result transaction with nothing outstanding: slot %0d", got.slot);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (got.slot !== exp.slot) begin
                $error("slot_index: expected %0d, actual %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.was_new !== exp.was_new) begin
                $error("was_new: expected %0b, actual %0b", exp.was_new, got.was_new);
                errors++;
            end
            if (got.did_evict !== exp.did_evict) begin
                $error("did_evict: expected %0b, actual %0b", exp.did_evict, got.did_evict);
                errors++;
            end
            if (got.evicted_id !== exp.evicted_id) begin
                $error("evicted_id: expected %h, actual %h", exp.evicted_id, got.evicted_id);
                errors++;
            end
            if (got.count !== exp.count) begin
                $error("entry_count: expected %0d, actual %0d", exp.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ID_W-1:0]          s_sender_id = '0;
    logic signed [RSSI_W-1:0] s_signal_rssi = '0;
    logic signed [SNR_W-1:0]  s_signal_snr = '0;
    logic [HOP_W-1:0]         s_hop_count = '0;
    logic [TIME_W-1:0]        s_now_ms = '0;
    logic                     s_position_present = 1'b0;
    logic signed [LAT_W-1:0]  s_latitude = '0;
    logic signed [LON_W-1:0]  s_longitude = '0;
    logic signed [ALT_W-1:0]  s_altitude = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [SLOT_OUT_W-1:0]    m_slot_index;
    logic                     m_was_new;
    logic                     m_did_evict;
    logic [ID_W-1:0]          m_evicted_id;
    logic [COUNT_OUT_W-1:0]   m_entry_count;

    roster_scoreboard sb;
    bit hurry = 1'b0;
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    neighbor_roster_lru_table_core #(
        .ROSTER_DEPTH(ROSTER_DEPTH)
    ) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic packet_t random_packet(logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
        packet_t p;
        p.sender_id = id;
        p.rssi = RSSI_W'($urandom_range(0, 250) - 200);
        p.snr = SNR_W'($urandom);
        p.hops = HOP_W'($urandom);
        p.now_ms = stamp;
        p.has_pos = 1'($urandom_range(0, 1));
        p.lat = LAT_W'($urandom_range(0, 1800000000) - 900000000);
        p.lon = LON_W'($urandom_range(0, 32'd3600000000) - 32'd1800000000);
        p.alt = ALT_W'($urandom);
        return p;
    endfunction

    function automatic logic [ID_W-1:0] pick_id(phase_kind_t kind);
        int roll;
        roll = $urandom_range(0, 99);
        if (sb.held > 0 && roll < (kind == PH_NOISE ? 10 : 35))
            return sb.ids[$urandom_range(0, sb.held - 1)];
        if (kind == PH_NOISE)
            return $urandom;
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_packet(input packet_t p);
        int gap;
        gap = hurry ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sender_id <= p.sender_id;
        s_signal_rssi <= p.rssi;
        s_signal_snr <= p.snr;
        s_hop_count <= p.hops;
        s_now_ms <= p.now_ms;
        s_position_present <= p.has_pos;
        s_latitude <= p.lat;
        s_longitude <= p.lon;
        s_altitude <= p.alt;
        do @(posedge aclk); while (!s_ready);
        sb.note_packet(p);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.awaited.size() != 0);
    endtask

    initial begin
        int stall;
        roster_update_t got;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = hurry ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            got.slot = m_slot_index;
            got.was_new = m_was_new;
            got.did_evict = m_did_evict;
            got.evicted_id = m_evicted_id;
            got.count = m_entry_count;
            sb.check_result(got);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        packet_t p;
        phase_kind_t kind;
        logic [TIME_W-1:0] stamp;
        int sent, span, roll;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, then refreshes with and without position, then new ids 1 to 15
        p = random_packet('0, '0);
        p.rssi = RSSI_W'(-200);
        p.snr = SNR_W'(-128);
        p.hops = '0;
        p.has_pos = 1'b1;
        p.lat = LAT_W'(-900000000);
        p.lon = LON_W'(-1800000000);
        p.alt = {1'b1, {(ALT_W-1){1'b0}}};
        send_packet(p);
        p = random_packet('1, '1);
        p.rssi = RSSI_W'(50);
        p.snr = SNR_W'(127);
        p.hops = '1;
        p.has_pos = 1'b1;
        p.lat = LAT_W'(900000000);
        p.lon = LON_W'(1800000000);
        p.alt = {1'b0, {(ALT_W-1){1'b1}}};
        send_packet(p);
        p = random_packet('0, 32'd10);
        p.has_pos = 1'b0;
        send_packet(p);
        p = random_packet('1, 32'd20);
        p.has_pos = 1'b1;
        send_packet(p);
        p = random_packet('0, 32'd30);
        p.rssi = '1;
        p.snr = '0;
        p.has_pos = 1'b1;
        send_packet(p);
        for (int i = 1; i <= DIRECTED_IDS; i++) begin
            p = random_packet(ID_W'(i), 32'd100);
            p.has_pos = i[0];
            send_packet(p);
        end
        wait_for_results();

        sent = 0;
        stamp = $urandom;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 5);
            kind = roll < 3 ? PH_CHURN : (roll < 5 ? PH_TIED : PH_NOISE);
            span = $urandom_range(30, 120);
            if (span > RANDOM_ITEMS - sent)
                span = RANDOM_ITEMS - sent;
            hurry = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                wait_for_results();
            for (int k = 0; k < POOL_SIZE; k++)
                id_pool[k] = $urandom;
            id_pool[0] = '0;
            id_pool[1] = '1;
            if (kind == PH_TIED || $urandom_range(0, 3) == 0)
                stamp = $urandom;
            repeat (span) begin
                p = random_packet(pick_id(kind), stamp);
                case (kind)
                    PH_CHURN: begin
                        stamp = stamp + $urandom_range(0, 40);
                        p.now_ms = stamp;
                    end
                    PH_TIED: begin
                        p.now_ms = stamp + $urandom_range(0, 1);
                    end
                    default: begin
                        roll = $urandom_range(0, 99);
                        p.now_ms = roll < 15 ? '0 : (roll < 30 ? '1 : TIME_W'($urandom));
                    end
                endcase
                send_packet(p);
                sent++;
            end
        end
        hurry = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d packets: %0d refreshes, %0d appends, %0d evictions,",
                 sb.checked, sb.refreshes, sb.appends, sb.evictions);
        $display("%0d of them on a tied oldest time; %0d mismatches", sb.tied, sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
